FILE: src/clist_pkg.sv
package clist_pkg;

    localparam int unsigned CAPACITY_DEF = 16;

    localparam int unsigned REQ_W    = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_BACK  = 3'd1,
        REQ_START     = 3'd2,
        REQ_NEXT      = 3'd3,
        REQ_REMOVE    = 3'd4
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOCUR = 2'd3
    } status_t;

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data_out;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

endpackage

FILE: src/circular_list_with_cursor.sv
// Bounded circular singly linked list with a traversal cursor, kept in a
// register-file node store of CAPACITY slots. Each request item (insert at
// front, insert at back, start traversal, next, remove current) gives exactly
// one result item carrying a status, a data word and the element count after
// the request. An accepted item is held in an input register; once the result
// register is free or being emptied, one pass of combinational logic reads the
// store, updates the pointers and loads the result register. A new item can be
// accepted every cycle while the result side does not stall; the rate is set
// by the one-pass read-modify-write of the node store and pointer
// registers. Insertion takes the lowest free slot and is refused with status
// full when none is left. Remove checks that the cursor is still linked behind
// its previous node and is refused with status no-cursor otherwise. Request
// codes 5 to 7 are ignored and answered with status ok.
module circular_list_with_cursor #(
    parameter int unsigned CAPACITY = clist_pkg::CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  clist_pkg::req_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output clist_pkg::rsp_t   m_data
);

    localparam int unsigned PTR_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // input register
    logic            in_valid_reg;
    clist_pkg::req_t in_item_reg;

    // result register
    logic            out_valid_reg;
    clist_pkg::rsp_t out_item_reg;
    clist_pkg::rsp_t out_item_next;

    // node store, no reset: only slots in use are ever read
    logic [clist_pkg::DATA_W-1:0] node_value_reg [CAPACITY];
    logic [PTR_W-1:0]             node_link_reg  [CAPACITY];

    // list control state
    logic [CAPACITY-1:0] in_use_reg,   in_use_next;
    logic [PTR_W-1:0]    tail_reg,     tail_next;
    logic [PTR_W-1:0]    cursor_reg,   cursor_next;
    logic [PTR_W-1:0]    prev_reg,     prev_next;
    logic                empty_reg,    empty_next;
    logic                cur_ok_reg,   cur_ok_next;
    logic [CNT_W-1:0]    count_reg,    count_next;

    // store write ports: one data word, up to two links per item
    logic                         val_we;
    logic [PTR_W-1:0]             val_waddr;
    logic                         link0_we;
    logic [PTR_W-1:0]             link0_waddr;
    logic [PTR_W-1:0]             link0_wdata;
    logic                         link1_we;
    logic [PTR_W-1:0]             link1_waddr;
    logic [PTR_W-1:0]             link1_wdata;

    // lowest free slot search
    logic                free_found;
    logic [PTR_W-1:0]    free_slot;

    // store reads at the few pointers that a request can touch
    logic [PTR_W-1:0]             head_slot;
    logic [PTR_W-1:0]             cur_link;
    logic [PTR_W-1:0]             prev_link;
    logic [PTR_W-1:0]             tail_link;

    logic [31:0] count_wide;
    logic        advance;

    // an item moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    // priority encoder, lowest index wins
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!in_use_reg[i]) begin
                free_found = 1'b1;
                free_slot  = PTR_W'(i);
            end
        end
    end

    assign tail_link = node_link_reg[tail_reg];
    assign head_slot = tail_link;
    assign cur_link  = node_link_reg[cursor_reg];
    assign prev_link = node_link_reg[prev_reg];

    // one pass of list update per item
    always_comb begin
        in_use_next = in_use_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        prev_next   = prev_reg;
        empty_next  = empty_reg;
        cur_ok_next = cur_ok_reg;
        count_next  = count_reg;

        val_we      = 1'b0;
        val_waddr   = free_slot;
        link0_we    = 1'b0;
        link0_waddr = free_slot;
        link0_wdata = free_slot;
        link1_we    = 1'b0;
        link1_waddr = tail_reg;
        link1_wdata = free_slot;

        out_item_next.status   = clist_pkg::ST_OK;
        out_item_next.data_out = '0;

        unique case (in_item_reg.req_type)
            clist_pkg::REQ_INS_FRONT, clist_pkg::REQ_INS_BACK: begin
                if (!free_found) begin
                    out_item_next.status = clist_pkg::ST_FULL;
                end else begin
                    val_we                 = 1'b1;
                    in_use_next[free_slot] = 1'b1;
                    link0_we               = 1'b1;
                    count_next             = count_reg + CNT_W'(1);
                    if (empty_reg) begin
                        // lone node links to itself
                        link0_wdata = free_slot;
                        tail_next   = free_slot;
                        empty_next  = 1'b0;
                    end else begin
                        // splice in after the tail, becoming the new head (or the new tail for insert at back)
                        link0_wdata = tail_link;
                        link1_we    = 1'b1;
                        if (in_item_reg.req_type == clist_pkg::REQ_INS_BACK) begin
                            tail_next = free_slot;
                        end
                    end
                end
            end
            clist_pkg::REQ_START: begin
                if (empty_reg) begin
                    out_item_next.status = clist_pkg::ST_EMPTY;
                end else begin
                    prev_next              = tail_reg;
                    cursor_next            = head_slot;
                    cur_ok_next            = 1'b1;
                    out_item_next.data_out = node_value_reg[head_slot];
                end
            end
            clist_pkg::REQ_NEXT: begin
                if (empty_reg) begin
                    out_item_next.status = clist_pkg::ST_EMPTY;
                end else if (!cur_ok_reg) begin
                    out_item_next.status = clist_pkg::ST_NOCUR;
                end else begin
                    prev_next              = cursor_reg;
                    cursor_next            = cur_link;
                    out_item_next.data_out = node_value_reg[cur_link];
                end
            end
            clist_pkg::REQ_REMOVE: begin
                if (empty_reg) begin
                    out_item_next.status = clist_pkg::ST_EMPTY;
                end else if (!cur_ok_reg || prev_link != cursor_reg) begin
                    // no valid cursor, or cursor no longer sits right behind its previous node
                    out_item_next.status = clist_pkg::ST_NOCUR;
                end else begin
                    out_item_next.data_out  = node_value_reg[cursor_reg];
                    in_use_next[cursor_reg] = 1'b0;
                    count_next              = count_reg - CNT_W'(1);
                    if (cursor_reg == tail_reg && cur_link == cursor_reg) begin
                        // last node gone
                        empty_next  = 1'b1;
                        cur_ok_next = 1'b0;
                        tail_next   = '0;
                        cursor_next = '0;
                        prev_next   = '0;
                    end else begin
                        if (cursor_reg == tail_reg) begin
                            tail_next = prev_reg;
                        end
                        link1_we    = 1'b1;
                        link1_waddr = prev_reg;
                        link1_wdata = cur_link;
                        cursor_next = prev_reg;
                    end
                end
            end
            default: begin
                // unknown codes leave everything as it is
            end
        endcase

        count_wide          = 32'(count_next);
        out_item_next.count = count_wide[clist_pkg::COUNT_W-1:0];
    end

    // node store
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (val_we) begin
                node_value_reg[val_waddr] <= in_item_reg.data_in;
            end
            if (link0_we) begin
                node_link_reg[link0_waddr] <= link0_wdata;
            end
            if (link1_we) begin
                node_link_reg[link1_waddr] <= link1_wdata;
            end
        end
    end

    // list control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
            tail_reg   <= '0;
            cursor_reg <= '0;
            prev_reg   <= '0;
            empty_reg  <= 1'b1;
            cur_ok_reg <= 1'b0;
            count_reg  <= '0;
        end else if (advance) begin
            in_use_reg <= in_use_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            prev_reg   <= prev_next;
            empty_reg  <= empty_next;
            cur_ok_reg <= cur_ok_next;
            count_reg  <= count_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

endmodule
